// ----- rtl/ssui_pkg.sv -----
package ssui_pkg;

  // Element word width
  localparam int WORD_W = 32;

  // Command codes carried on the input channel
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_UNION  = 2'd2,
    CMD_ISECT  = 2'd3
  } cmd_t;

endpackage

// ----- rtl/ssui_if.sv -----
// Input channel: one command beat per item
interface ssui_in_if;
  logic                               valid;
  logic                               ready;
  ssui_pkg::cmd_t                     cmd;
  logic signed [ssui_pkg::WORD_W-1:0] element_value;

  modport source (output valid, output cmd, output element_value, input ready);
  modport sink   (input valid, input cmd, input element_value, output ready);
endinterface

// Result channel: one member of the answer per beat
interface ssui_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ssui_pkg::WORD_W-1:0] result_value;
  logic                               result_valid;
  logic                               result_last;
  logic                               load_overflow;

  modport source (output valid, output result_value, output result_valid,
                  output result_last, output load_overflow, input ready);
  modport sink   (input valid, input result_value, input result_valid,
                  input result_last, input load_overflow, output ready);
endinterface

// ----- rtl/ssui_ram.sv -----
// Simple dual-port RAM: one write port, one read port, registered read
module ssui_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sorted_set_union_intersection_core.sv -----
// Sorted set union / intersection engine.
// Input channel in_ch carries a command and an element. Load commands append
// the element to the first or second set (no result beat); a load into a
// full set is dropped and remembered as an overflow. A union or
// intersection command merges both sets in one ascending pass and emits
// the answer on out_ch, one member per beat, with result_last on the final
// beat. An empty answer gives a single beat with result_valid low. Every
// result beat carries the overflow flag. After a compute both sets and the
// overflow flag are empty again.
// Timing: a load is taken every cycle while the block is idle. A compute
// holds in_ch.ready low through every merge step (RAM read, then compare in
// the shared comparator) and while the last beat is closed in S_DONE; the
// registered RAM read sets the read-then-compare step. A member is held in a
// pending register until the next member is found or the merge ends, to
// learn whether it is the last; only then does it leave as a result.
// If out_ch stalls, the merge pauses at the next member to be pushed; the
// output register holds the beat until taken. Reset (synchronous, active
// low) empties both sets, clears the overflow flag and drops any result.
module sorted_set_union_intersection_core #(
  parameter int SET_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  ssui_in_if.sink           in_ch,
  ssui_out_if.source        out_ch
);

  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CW = $clog2(SET_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);
  localparam int WW = ssui_pkg::WORD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  state_t          state_r;
  logic            is_union_r;
  logic [CW-1:0]   first_cnt_r;
  logic [CW-1:0]   second_cnt_r;
  logic [CW-1:0]   i_r;
  logic [CW-1:0]   j_r;
  logic            ovf_r;
  logic            pend_v_r;
  logic [WW-1:0]   pend_val_r;
  logic            out_v_r;
  logic [WW-1:0]   out_val_r;
  logic            out_mem_r;
  logic            out_last_r;
  logic            out_ovf_r;

  logic            accept;
  logic            load_a;
  logic            load_b;
  logic            out_free;
  logic [WW-1:0]   rd_a;
  logic [WW-1:0]   rd_b;
  logic            has_a;
  logic            has_b;
  logic            heads_eq;
  logic            a_less;
  logic            take_a;
  logic            take_b;
  logic            emit;
  logic [WW-1:0]   emit_val;
  logic            merge_done;
  logic            stall;

  // Handshake and load decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_a      = accept && (in_ch.cmd == ssui_pkg::CMD_LOAD_A)
                       && (first_cnt_r < DEPTH_C);
  assign load_b      = accept && (in_ch.cmd == ssui_pkg::CMD_LOAD_B)
                       && (second_cnt_r < DEPTH_C);
  assign out_free    = !out_v_r || out_ch.ready;

  // Set stores
  ssui_ram #(.WIDTH(WW), .DEPTH(SET_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (load_a),
    .waddr (first_cnt_r[AW-1:0]),
    .wdata (in_ch.element_value),
    .raddr (i_r[AW-1:0]),
    .rdata (rd_a)
  );

  ssui_ram #(.WIDTH(WW), .DEPTH(SET_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (load_b),
    .waddr (second_cnt_r[AW-1:0]),
    .wdata (in_ch.element_value),
    .raddr (j_r[AW-1:0]),
    .rdata (rd_b)
  );

  // Shared comparator and merge step decision
  assign has_a    = i_r < first_cnt_r;
  assign has_b    = j_r < second_cnt_r;
  assign heads_eq = rd_a == rd_b;
  assign a_less   = $signed(rd_a) < $signed(rd_b);

  always_comb begin
    take_a   = 1'b0;
    take_b   = 1'b0;
    emit     = 1'b0;
    emit_val = rd_a;
    if (has_a && has_b) begin
      if (heads_eq) begin
        take_a = 1'b1;
        take_b = 1'b1;
        emit   = 1'b1;
      end else if (a_less) begin
        take_a = 1'b1;
        emit   = is_union_r;
      end else begin
        take_b   = 1'b1;
        emit     = is_union_r;
        emit_val = rd_b;
      end
    end else if (has_a) begin
      take_a = 1'b1;
      emit   = is_union_r;
    end else if (has_b) begin
      take_b   = 1'b1;
      emit     = is_union_r;
      emit_val = rd_b;
    end
  end

  // intersection ends as soon as either side runs out
  assign merge_done = is_union_r ? !(has_a || has_b) : !(has_a && has_b);
  assign stall      = emit && pend_v_r && !out_free;

  // Sequencer, set counts and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      is_union_r   <= 1'b0;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      i_r          <= '0;
      j_r          <= '0;
      ovf_r        <= 1'b0;
      pend_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.cmd)
              ssui_pkg::CMD_LOAD_A: begin
                if (load_a) begin
                  first_cnt_r <= first_cnt_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              ssui_pkg::CMD_LOAD_B: begin
                if (load_b) begin
                  second_cnt_r <= second_cnt_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              default: begin
                is_union_r <= (in_ch.cmd == ssui_pkg::CMD_UNION);
                i_r        <= '0;
                j_r        <= '0;
                pend_v_r   <= 1'b0;
                state_r    <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (merge_done) begin
            state_r <= S_DONE;
          end else if (!stall) begin
            if (take_a) begin
              i_r <= i_r + 1'b1;
            end
            if (take_b) begin
              j_r <= j_r + 1'b1;
            end
            if (emit) begin
              // held member is not the last one: push it
              if (pend_v_r) begin
                out_v_r    <= 1'b1;
                out_val_r  <= pend_val_r;
                out_mem_r  <= 1'b1;
                out_last_r <= 1'b0;
                out_ovf_r  <= ovf_r;
              end
              pend_val_r <= emit_val;
              pend_v_r   <= 1'b1;
            end
            state_r <= S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_v_r      <= 1'b1;
            out_val_r    <= pend_v_r ? pend_val_r : '0;
            out_mem_r    <= pend_v_r;
            out_last_r   <= 1'b1;
            out_ovf_r    <= ovf_r;
            pend_v_r     <= 1'b0;
            first_cnt_r  <= '0;
            second_cnt_r <= '0;
            ovf_r        <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.result_value  = out_val_r;
  assign out_ch.result_valid  = out_mem_r;
  assign out_ch.result_last   = out_last_r;
  assign out_ch.load_overflow = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_cnt_r <= DEPTH_C && second_cnt_r <= DEPTH_C)
    else $error("set count exceeds depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> (i_r <= first_cnt_r && j_r <= second_cnt_r))
    else $error("merge index ran past set end");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=>
      (first_cnt_r == '0 && second_cnt_r == '0 && !ovf_r && !pend_v_r))
    else $error("sets not emptied after compute");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_mem_r) |-> out_last_r)
    else $error("empty answer beat without last flag");
`endif

endmodule

// ----- tb/ssui_checker.sv -----
// Watches both channels, tracks the two sets and checks every result beat
// against the merge it predicts.
module ssui_checker #(
  parameter int SET_DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  ssui_in_if   in_mon,
  ssui_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic signed [ssui_pkg::WORD_W-1:0] value;
    logic                               member;
    logic                               last;
    logic                               ovf;
  } result_beat_t;

  // predicted block state
  logic signed [ssui_pkg::WORD_W-1:0] first_words  [SET_DEPTH];
  logic signed [ssui_pkg::WORD_W-1:0] second_words [SET_DEPTH];
  int                                 first_n;
  int                                 second_n;
  logic                               ovf_seen;

  // answer beats still owed by the block, oldest first
  result_beat_t beats_due[$];

  task automatic owe_beat(input logic signed [ssui_pkg::WORD_W-1:0] v,
                          input logic member);
    result_beat_t b;
    b.value  = v;
    b.member = member;
    b.last   = 1'b0;
    b.ovf    = ovf_seen;
    beats_due.push_back(b);
  endtask

  // one ascending pass over both sets, same tie and tail rules as the block
  task automatic merge_sets(input ssui_pkg::cmd_t op);
    int                                 i;
    int                                 j;
    int                                 start_cnt;
    logic signed [ssui_pkg::WORD_W-1:0] a;
    logic signed [ssui_pkg::WORD_W-1:0] b;
    result_beat_t                       tail;
    i = 0;
    j = 0;
    start_cnt = beats_due.size();
    while (i < first_n && j < second_n) begin
      a = first_words[i];
      b = second_words[j];
      if (a == b) begin
        owe_beat(a, 1'b1);
        i++;
        j++;
      end else if (a < b) begin
        if (op == ssui_pkg::CMD_UNION) owe_beat(a, 1'b1);
        i++;
      end else begin
        if (op == ssui_pkg::CMD_UNION) owe_beat(b, 1'b1);
        j++;
      end
    end
    if (op == ssui_pkg::CMD_UNION) begin
      while (i < first_n) begin
        owe_beat(first_words[i], 1'b1);
        i++;
      end
      while (j < second_n) begin
        owe_beat(second_words[j], 1'b1);
        j++;
      end
    end
    // empty answer still gives one beat, not a member
    if (beats_due.size() == start_cnt) owe_beat('0, 1'b0);
    tail = beats_due.pop_back();
    tail.last = 1'b1;
    beats_due.push_back(tail);
    first_n  = 0;
    second_n = 0;
    ovf_seen = 1'b0;
  endtask

  task automatic check_beat();
    result_beat_t e;
    if (beats_due.size() == 0) begin
      $display("%0t: result beat with nothing expected: value=%0d valid=%b last=%b ovf=%b",
               $time, out_mon.result_value, out_mon.result_valid, out_mon.result_last,
               out_mon.load_overflow);
      fail_count++;
    end else begin
      e = beats_due.pop_front();
      if (out_mon.result_value !== e.value) begin
        $display("%0t: result_value expected %0d actual %0d",
                 $time, e.value, out_mon.result_value);
        fail_count++;
      end
      if (out_mon.result_valid !== e.member) begin
        $display("%0t: result_valid expected %b actual %b",
                 $time, e.member, out_mon.result_valid);
        fail_count++;
      end
      if (out_mon.result_last !== e.last) begin
        $display("%0t: result_last expected %b actual %b",
                 $time, e.last, out_mon.result_last);
        fail_count++;
      end
      if (out_mon.load_overflow !== e.ovf) begin
        $display("%0t: load_overflow expected %b actual %b",
                 $time, e.ovf, out_mon.load_overflow);
        fail_count++;
      end
    end
  endtask

  // input beats update the prediction, output beats are checked
  always @(posedge clk) begin
    if (!rst_n) begin
      first_n  = 0;
      second_n = 0;
      ovf_seen = 1'b0;
      beats_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          ssui_pkg::CMD_LOAD_A: begin
            if (first_n < SET_DEPTH) begin
              first_words[first_n] = in_mon.element_value;
              first_n++;
            end else begin
              ovf_seen = 1'b1;
            end
          end
          ssui_pkg::CMD_LOAD_B: begin
            if (second_n < SET_DEPTH) begin
              second_words[second_n] = in_mon.element_value;
              second_n++;
            end else begin
              ovf_seen = 1'b1;
            end
          end
          ssui_pkg::CMD_UNION, ssui_pkg::CMD_ISECT: begin
            merge_sets(in_mon.cmd);
          end
          default: begin
            $display("%0t: unknown command %b on input", $time, in_mon.cmd);
            fail_count++;
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_beat();
    end
    pending <= beats_due.size();
  end

endmodule

// ----- tb/tb_sorted_set_union_intersection_core.sv -----
// Drives load and merge commands into the core with random gaps and
// output stalls; the checker beside it does the scoring.
module tb_sorted_set_union_intersection_core;

  localparam int SET_DEPTH    = 32;
  localparam int RANDOM_ITEMS = 145;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   directed_items;
  bit   steady;

  ssui_in_if  in_ch();
  ssui_out_if out_ch();

  sorted_set_union_intersection_core #(
    .SET_DEPTH(SET_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ssui_checker #(
    .SET_DEPTH(SET_DEPTH)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

  // mostly short idle stretches, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random element: extremes, a narrow band near zero, or any word
  function automatic int pick_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return -1;
          default: return 0;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // result side backpressure
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        hold = pick_gap();
        out_ch.ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  // one input beat, after an optional idle gap
  task automatic send_item(input ssui_pkg::cmd_t c,
                           input logic signed [ssui_pkg::WORD_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= c;
    in_ch.element_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // load two sets with interleaved beats, then merge them
  task automatic run_sets(input int na, input int nb, input int share_pct,
                          input bit ordered, input ssui_pkg::cmd_t op);
    int pool[$];
    int uniq[$];
    int set_a[$];
    int set_b[$];
    int ia;
    int ib;
    bit to_a;
    if (ordered) begin
      repeat (na + nb) pool.push_back(pick_word());
      pool.sort();
      foreach (pool[k]) begin
        if (uniq.size() == 0 || uniq[uniq.size()-1] != pool[k]) uniq.push_back(pool[k]);
      end
      foreach (uniq[k]) begin
        if (set_a.size() < na && set_b.size() < nb &&
            $urandom_range(0, 99) < share_pct) begin
          set_a.push_back(uniq[k]);
          set_b.push_back(uniq[k]);
        end else if (set_a.size() < na && (set_b.size() >= nb || $urandom_range(0, 1))) begin
          set_a.push_back(uniq[k]);
        end else if (set_b.size() < nb) begin
          set_b.push_back(uniq[k]);
        end
      end
    end else begin
      // unsorted, with repeats
      repeat (na) set_a.push_back($urandom_range(0, 7) - 4);
      repeat (nb) set_b.push_back($urandom_range(0, 7) - 4);
    end
    ia = 0;
    ib = 0;
    while (ia < set_a.size() || ib < set_b.size()) begin
      if (ia >= set_a.size()) to_a = 1'b0;
      else if (ib >= set_b.size()) to_a = 1'b1;
      else to_a = $urandom_range(0, 1);
      if (to_a) begin
        send_item(ssui_pkg::CMD_LOAD_A, set_a[ia]);
        ia++;
      end else begin
        send_item(ssui_pkg::CMD_LOAD_B, set_b[ib]);
        ib++;
      end
    end
    send_item(op, $urandom);
  endtask

  function automatic ssui_pkg::cmd_t pick_op();
    return $urandom_range(0, 1) ? ssui_pkg::CMD_UNION : ssui_pkg::CMD_ISECT;
  endfunction

  // stimulus and verdict
  initial begin
    int  k;
    bit  first_pass;
    items_sent          = 0;
    steady              = 1'b0;
    first_pass          = 1'b1;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= ssui_pkg::CMD_LOAD_A;
    in_ch.element_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // both sets empty
    send_item(ssui_pkg::CMD_UNION, 32'h0);
    send_item(ssui_pkg::CMD_ISECT, 32'h7fff_ffff);
    // word extremes on both sides
    send_item(ssui_pkg::CMD_LOAD_A, 32'h8000_0000);
    send_item(ssui_pkg::CMD_LOAD_A, 32'hffff_ffff);
    send_item(ssui_pkg::CMD_LOAD_A, 32'h0000_0000);
    send_item(ssui_pkg::CMD_LOAD_A, 32'h7fff_ffff);
    send_item(ssui_pkg::CMD_LOAD_B, 32'h8000_0000);
    send_item(ssui_pkg::CMD_LOAD_B, 32'sd5);
    send_item(ssui_pkg::CMD_LOAD_B, 32'h7fff_ffff);
    send_item(ssui_pkg::CMD_UNION, 32'hffff_ffff);
    // disjoint sets, no common member
    send_item(ssui_pkg::CMD_LOAD_A, 32'hffff_ffff);
    send_item(ssui_pkg::CMD_LOAD_A, 32'h7fff_ffff);
    send_item(ssui_pkg::CMD_LOAD_B, 32'h0000_0000);
    send_item(ssui_pkg::CMD_ISECT, 32'h5555_5555);
    // only the first set loaded
    send_item(ssui_pkg::CMD_LOAD_A, 32'sd3);
    send_item(ssui_pkg::CMD_LOAD_A, 32'sd7);
    send_item(ssui_pkg::CMD_ISECT, 32'haaaa_aaaa);
    // only the second set loaded
    send_item(ssui_pkg::CMD_LOAD_B, 32'h5555_5555);
    send_item(ssui_pkg::CMD_UNION, 32'h0);
    // unsorted first set with a repeat
    send_item(ssui_pkg::CMD_LOAD_A, 32'sd9);
    send_item(ssui_pkg::CMD_LOAD_A, 32'sd2);
    send_item(ssui_pkg::CMD_LOAD_A, 32'sd2);
    send_item(ssui_pkg::CMD_LOAD_B, 32'sd2);
    send_item(ssui_pkg::CMD_LOAD_B, 32'sd9);
    send_item(ssui_pkg::CMD_ISECT, 32'h0);
    directed_items = items_sent;

    // random sequences, mostly well formed
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      k = $urandom_range(0, 19);
      if (first_pass) begin
        // full second set, first set one past full, unsorted with repeats
        run_sets(SET_DEPTH + 1, SET_DEPTH, 0, 1'b0, ssui_pkg::CMD_UNION);
        first_pass = 1'b0;
      end else if (k == 0) begin
        run_sets($urandom_range(10, SET_DEPTH), $urandom_range(10, SET_DEPTH),
                 $urandom_range(0, 100), 1'b1, pick_op());
      end else if (k < 3) begin
        run_sets($urandom_range(0, 5), $urandom_range(0, 5), 0, 1'b0, pick_op());
      end else if (k == 3) begin
        send_item(pick_op(), $urandom);
      end else begin
        run_sets($urandom_range(0, 6), $urandom_range(0, 6),
                 $urandom_range(0, 100), 1'b1, pick_op());
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // drain, then a quiet tail
    do @(posedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (pending != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
